### design/lcma_pkg.sv
// lcma_pkg: shared types and constants for the calibrated load-cell averager
// no dependencies; used by lcma_cell and load_cell_calibrated_moving_average_unit

package lcma_pkg;

    localparam int RAW_W   = 24;
    localparam int DIFF_W  = 25;
    localparam int MASS_W  = 32;
    localparam int PROD_W  = 57;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 2;

    // force constant 0.00981 in Q0.32
    localparam int          FORCE_K_W = 26;
    localparam int          FPROD_W   = 58;
    localparam logic [FORCE_K_W-1:0] FORCE_K = 26'd42133629;

    localparam logic signed [MASS_W-1:0] MASS_MAX = 32'sh7fffffff;
    localparam logic signed [MASS_W-1:0] MASS_MIN = 32'sh80000000;

    localparam logic signed [31:0] INV_SCALE_RESET = 32'sd65536;

    typedef enum logic [INDEX_W-1:0] {
        REG_ZERO_OFFSET   = 2'd0,
        REG_INVERSE_SCALE = 2'd1
    } t_reg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SAT,
        ST_ACC,
        ST_ABS,
        ST_QLO,
        ST_QHI,
        ST_FIX,
        ST_FRC,
        ST_OUT
    } t_state;

endpackage

### design/load_cell_calibrated_moving_average_unit.sv
// load_cell_calibrated_moving_average_unit: top level of the load-cell averager
// depends on lcma_pkg and lcma_cell (chain of TAPS window cells)
//
// usage
//   input channel: i_valid / o_ready carry one signed 24-bit converter request
//   (i_raw_sample); output channel: o_valid / i_ready carry the window mean of
//   calibrated mass, the matching force (both signed Q16.16) and a clip flag
//   config port: i_cfg_we with i_cfg_index 0 = zero offset, 1 = inverse scale;
//   other indexes are ignored; write only while the block is idle
// timing
//   one request at a time through a ten-step sequencer: accept, multiply,
//   saturate, window update, magnitude, two reciprocal partial products,
//   quotient fix-up, force multiply, output load; a new request is taken
//   only once the previous one has left the output load step
//   the mean divides by TAPS through a 32-bit reciprocal multiplied with
//   the low and high halves of the sum magnitude, which sets the step count
// reset
//   synchronous active-low reset clears the window cells, running sum,
//   sequencer and output valid flag, and loads offset 0 and scale 1.0
// stall
//   a finished result sits in the output register; the next request is still
//   accepted and only waits in its last step while the receiver holds off

module load_cell_calibrated_moving_average_unit #(
    parameter int TAPS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input channel
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [lcma_pkg::RAW_W-1:0]       i_raw_sample,
    // output channel
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [lcma_pkg::MASS_W-1:0]      o_filtered_mass,
    output logic signed [lcma_pkg::MASS_W-1:0]      o_filtered_force,
    output logic                                    o_clipped,
    // config port
    input  logic                                    i_cfg_we,
    input  logic [lcma_pkg::INDEX_W-1:0]            i_cfg_index,
    input  logic [lcma_pkg::DATA_W-1:0]             i_cfg_data
);

    // sum of TAPS 32-bit masses needs clog2(TAPS) more bits
    localparam int L_W    = $clog2(TAPS);
    localparam int SUM_W  = 32 + L_W;
    localparam int LO_W   = SUM_W / 2;
    localparam int HI_W   = SUM_W - LO_W;
    localparam int PW     = SUM_W + 32;
    localparam int SHIFT  = 31 + L_W;
    // floor(2^SHIFT / TAPS), always below 2^32; estimate is low by at most one
    localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(TAPS);
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];

    // config registers
    logic signed [lcma_pkg::RAW_W-1:0]  r_zero_offset;
    logic signed [31:0]                 r_inv_scale;

    // sequencer
    lcma_pkg::t_state r_state, n_state;

    // datapath registers
    logic signed [lcma_pkg::DIFF_W-1:0] r_diff;
    logic signed [lcma_pkg::PROD_W-1:0] r_prod;
    logic signed [lcma_pkg::MASS_W-1:0] r_mass;
    logic                               r_clip;
    logic signed [SUM_W-1:0]            r_sum;
    logic                               r_neg;
    logic [SUM_W-1:0]                   r_mag;
    logic [LO_W+31:0]                   r_plo;
    logic [31:0]                        r_qest;
    logic [31:0]                        r_q;
    logic [lcma_pkg::FPROD_W-1:0]       r_fprod;
    logic signed [lcma_pkg::MASS_W-1:0] r_mean;

    // output register
    logic                               r_out_valid;
    logic signed [lcma_pkg::MASS_W-1:0] r_out_mass;
    logic signed [lcma_pkg::MASS_W-1:0] r_out_force;
    logic                               r_out_clip;

    // next values
    logic signed [lcma_pkg::DIFF_W-1:0] n_diff;
    logic signed [lcma_pkg::PROD_W-1:0] n_prod;
    logic signed [lcma_pkg::MASS_W-1:0] n_mass;
    logic                               n_clip;
    logic signed [SUM_W-1:0]            n_sum;
    logic [SUM_W-1:0]                   n_mag;
    logic [LO_W+31:0]                   n_plo;
    logic [PW-1:0]                      n_pfull;
    logic [31:0]                        n_q;
    logic [lcma_pkg::FPROD_W-1:0]       n_fprod;
    logic signed [lcma_pkg::MASS_W-1:0] n_mean;
    logic signed [lcma_pkg::MASS_W-1:0] n_force;
    logic [lcma_pkg::FPROD_W-1:0]       w_fround;
    logic [HI_W+31:0]                   w_phi;
    logic [SUM_W-1:0]                   w_rem;
    logic                               w_load_out;
    logic                               w_shift;

    // window cell chain: w_tap[0] is the new mass, w_tap[TAPS] the oldest
    logic signed [lcma_pkg::MASS_W-1:0] w_tap [0:TAPS];

    assign w_tap[0] = r_mass;

    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        lcma_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_data  (w_tap[g]),
            .o_data  (w_tap[g+1])
        );
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= '0;
            r_inv_scale   <= lcma_pkg::INV_SCALE_RESET;
        end else if (i_cfg_we) begin
            case (lcma_pkg::t_reg_index'(i_cfg_index))
                lcma_pkg::REG_ZERO_OFFSET:   r_zero_offset <= i_cfg_data[23:0];
                lcma_pkg::REG_INVERSE_SCALE: r_inv_scale   <= i_cfg_data;
                default: ; // index beyond the register list is dropped
            endcase
        end
    end

    assign o_ready = (r_state == lcma_pkg::ST_IDLE);

    // datapath arithmetic, one step per state
    always_comb begin
        // tare subtraction, exact in 25 bits
        n_diff  = lcma_pkg::DIFF_W'(i_raw_sample) - lcma_pkg::DIFF_W'(r_zero_offset);
        // calibration multiply, 25 x 32 signed
        n_prod  = lcma_pkg::PROD_W'(r_diff) * lcma_pkg::PROD_W'(r_inv_scale);
        // saturate to 32 bits: clip when the upper bits are not a sign extension
        n_clip  = (r_prod[56:31] != {26{r_prod[56]}});
        if (n_clip) begin
            n_mass = r_prod[56] ? lcma_pkg::MASS_MIN : lcma_pkg::MASS_MAX;
        end else begin
            n_mass = r_prod[31:0];
        end
        // running sum: drop oldest cell, add newest
        n_sum   = r_sum + SUM_W'(r_mass) - SUM_W'(w_tap[TAPS]);
        n_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        // reciprocal product in two halves
        n_plo   = (LO_W+32)'(r_mag[LO_W-1:0]) * (LO_W+32)'(RECIP);
        w_phi   = (HI_W+32)'(r_mag[SUM_W-1:LO_W]) * (HI_W+32)'(RECIP);
        n_pfull = (PW'(w_phi) << LO_W) + PW'(r_plo);
        // one-step fix-up of the truncated quotient
        w_rem   = r_mag - (SUM_W'(r_qest) * SUM_W'(TAPS));
        n_q     = (w_rem >= SUM_W'(TAPS)) ? (r_qest + 32'd1) : r_qest;
        // force from mean magnitude, rounded half away from zero
        n_fprod = lcma_pkg::FPROD_W'(r_q) * lcma_pkg::FPROD_W'(lcma_pkg::FORCE_K);
        n_mean  = r_neg ? -$signed(r_q) : $signed(r_q);
        w_fround = r_fprod + (lcma_pkg::FPROD_W'(1) << 31);
        n_force = r_neg ? -$signed(32'(w_fround[57:32])) : $signed(32'(w_fround[57:32]));
    end

    // sequencer next state and step controls
    always_comb begin
        n_state    = r_state;
        w_shift    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            lcma_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = lcma_pkg::ST_MUL;
                end
            end
            lcma_pkg::ST_MUL: n_state = lcma_pkg::ST_SAT;
            lcma_pkg::ST_SAT: n_state = lcma_pkg::ST_ACC;
            lcma_pkg::ST_ACC: begin
                w_shift = 1'b1;
                n_state = lcma_pkg::ST_ABS;
            end
            lcma_pkg::ST_ABS: n_state = lcma_pkg::ST_QLO;
            lcma_pkg::ST_QLO: n_state = lcma_pkg::ST_QHI;
            lcma_pkg::ST_QHI: n_state = lcma_pkg::ST_FIX;
            lcma_pkg::ST_FIX: n_state = lcma_pkg::ST_FRC;
            lcma_pkg::ST_FRC: n_state = lcma_pkg::ST_OUT;
            lcma_pkg::ST_OUT: begin
                // wait here only while the previous result is still held
                if (!r_out_valid || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = lcma_pkg::ST_IDLE;
                end
            end
            default: n_state = lcma_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcma_pkg::ST_IDLE;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == lcma_pkg::ST_ACC) begin
                r_sum <= n_sum;
            end
        end
    end

    // payload steps, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            lcma_pkg::ST_IDLE: r_diff <= n_diff;
            lcma_pkg::ST_MUL:  r_prod <= n_prod;
            lcma_pkg::ST_SAT: begin
                r_mass <= n_mass;
                r_clip <= n_clip;
            end
            lcma_pkg::ST_ABS: begin
                r_neg <= r_sum[SUM_W-1];
                r_mag <= n_mag;
            end
            lcma_pkg::ST_QLO: r_plo   <= n_plo;
            lcma_pkg::ST_QHI: r_qest  <= n_pfull[SHIFT+31:SHIFT];
            lcma_pkg::ST_FIX: r_q     <= n_q;
            lcma_pkg::ST_FRC: begin
                r_fprod <= n_fprod;
                r_mean  <= n_mean;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_mass  <= r_mean;
            r_out_force <= n_force;
            r_out_clip  <= r_clip;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_filtered_mass  = r_out_mass;
    assign o_filtered_force = r_out_force;
    assign o_clipped        = r_out_clip;

`ifndef NO_ASSERTIONS
    // an accepted request starts the multiply step next cycle
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == lcma_pkg::ST_MUL))
        else $error("accepted request did not enter multiply step");

    // a clipped mass is one of the two saturation bounds
    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == lcma_pkg::ST_ACC) && r_clip) |->
        ((r_mass == lcma_pkg::MASS_MAX) || (r_mass == lcma_pkg::MASS_MIN)))
        else $error("clip flag set without saturated mass");

    // reciprocal estimate never falls more than one below the true quotient
    a_recip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcma_pkg::ST_FIX) |-> (w_rem < SUM_W'(2 * TAPS)))
        else $error("reciprocal quotient estimate out of range");

    // a new result only appears from the output step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == lcma_pkg::ST_OUT))
        else $error("output loaded outside output step");
`endif

endmodule

### design/lcma_cell.sv
// lcma_cell: one window cell, holds one calibrated mass and passes it on
// depends on lcma_pkg for the mass width

module lcma_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_shift,
    input  logic signed [lcma_pkg::MASS_W-1:0]   i_data,
    output logic signed [lcma_pkg::MASS_W-1:0]   o_data
);

    logic signed [lcma_pkg::MASS_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule
